// File: design/xs256_pkg.sv
// ----------------------------------------------------------------------------
// xs256_pkg
// Shared types and constants for the xoshiro256** generator core: the
// splitmix64 seeding constants and the command group that passes from the
// controller to the datapath.
// ----------------------------------------------------------------------------
package xs256_pkg;

    localparam int WordWidth     = 64;
    localparam int HalfWidth     = 32;
    localparam int NumWords      = 4;
    localparam int WordIdxWidth  = 2;
    localparam int FracWidth     = 52;
    localparam int FracShift     = 12;
    localparam int OutDataWidth  = 120;

    localparam logic [WordWidth-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WordWidth-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WordWidth-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

    // Input command codes carried on the stream's tuser bit.
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Partial-product phases of the shared 32x32 multiplier.
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_LO_HI = 2'd1;
    localparam logic [1:0] MUL_HI_LO = 2'd2;

    // Multiplier constant selection.
    localparam logic MUL_SEL_A = 1'b0;
    localparam logic MUL_SEL_B = 1'b1;

    typedef struct packed {
        logic                    load_seed;
        logic                    draw;
        logic                    inc;
        logic                    mul_en;
        logic [1:0]              mul_phase;
        logic                    mul_sel;
        logic                    mix27;
        logic                    store;
        logic [WordIdxWidth-1:0] word_idx;
    } dp_cmd_t;

endpackage

// File: design/xoshiro256_starstar_generator_core.sv
// ----------------------------------------------------------------------------
// xoshiro256_starstar_generator_core
// Xoshiro256** pseudo-random generator with splitmix64 seeding. A draw request
// returns the scrambled value and its 52-bit unit fraction; a seed request
// refills the four state words and returns nothing.
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tuser: command; tdata: seed
// m_*       out        m_tvalid/m_tready   tdata: value, unit_fraction
//
// A draw takes one cycle: its result is registered at the accepting edge, and
// a new request may be taken in the next cycle if that result is taken then.
// A seed keeps the core busy after acceptance: each state word takes the counter
// step, two splitmix products (each formed by the single 32x32 multiplier in three
// partial products) and its store; no request is taken during that time.
// After reset the state is all zero and draws return zero.
// A stalled output holds its result and blocks further requests.
// ----------------------------------------------------------------------------
module xoshiro256_starstar_generator_core
    import xs256_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [WordWidth-1:0]    s_tdata,   // [63:0] seed
    input  logic                    s_tuser,   // [0] command
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataWidth-1:0] m_tdata    // [63:0] value, [115:64] unit_fraction
);

    dp_cmd_t              cmd;
    logic [WordWidth-1:0] value;
    logic [FracWidth-1:0] unit_fraction;

    // Sequencing and handshake control.
    xs256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd)
    );

    // State, scrambler and seed mixer.
    xs256_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .seed          (s_tdata),
        .value         (value),
        .unit_fraction (unit_fraction)
    );

    // Output packing with zero fill to a whole number of bytes.
    assign m_tdata = {{(OutDataWidth - WordWidth - FracWidth){1'b0}}, unit_fraction, value};

endmodule

// File: design/xs256_ctrl.sv
// ----------------------------------------------------------------------------
// xs256_ctrl
// Controller for the generator: accepts requests, sequences the splitmix64
// seeding through the shared multiplier and holds the output valid flag.
// ----------------------------------------------------------------------------
module xs256_ctrl
    import xs256_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_command,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INC   = 4'd1;
    localparam logic [3:0] ST_MA0   = 4'd2;
    localparam logic [3:0] ST_MA1   = 4'd3;
    localparam logic [3:0] ST_MA2   = 4'd4;
    localparam logic [3:0] ST_X27   = 4'd5;
    localparam logic [3:0] ST_MB0   = 4'd6;
    localparam logic [3:0] ST_MB1   = 4'd7;
    localparam logic [3:0] ST_MB2   = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [WordIdxWidth-1:0] word_reg;
    logic [WordIdxWidth-1:0] word_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    accept;

    // A new request is taken only in idle and when the output slot is free
    // or being emptied in the same cycle.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        cmd           = '0;
        cmd.word_idx  = word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_command == CMD_DRAW))
                begin
                    cmd.draw = 1'b1;
                end
                else if (accept)
                begin
                    cmd.load_seed = 1'b1;
                    word_next     = '0;
                    state_next    = ST_INC;
                end
            end
            ST_INC:
            begin
                cmd.inc    = 1'b1;
                state_next = ST_MA0;
            end
            ST_MA0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_LO;
                cmd.mul_sel   = MUL_SEL_A;
                state_next    = ST_MA1;
            end
            ST_MA1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_HI;
                cmd.mul_sel   = MUL_SEL_A;
                state_next    = ST_MA2;
            end
            ST_MA2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_HI_LO;
                cmd.mul_sel   = MUL_SEL_A;
                state_next    = ST_X27;
            end
            ST_X27:
            begin
                cmd.mix27  = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_LO;
                cmd.mul_sel   = MUL_SEL_B;
                state_next    = ST_MB1;
            end
            ST_MB1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_HI;
                cmd.mul_sel   = MUL_SEL_B;
                state_next    = ST_MB2;
            end
            ST_MB2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_HI_LO;
                cmd.mul_sel   = MUL_SEL_B;
                state_next    = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                word_next = word_reg + 1'b1;
                if (word_reg == WordIdxWidth'(NumWords - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set by a draw, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.draw)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request is never taken while seeding is in progress.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready raised outside idle");

    // A seed request starts the seeding sequence on the first word.
    a_seed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_command == CMD_SEED)) |=> (state_reg == ST_INC) && (word_reg == '0))
        else $error("seed request did not start seeding");

    // A draw request always leaves a result pending.
    a_draw_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_command == CMD_DRAW)) |=> out_valid_reg)
        else $error("draw gave no result");

    // A result only appears after a draw.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && (in_command == CMD_DRAW)))
        else $error("result appeared without a draw");

endmodule

// File: design/xs256_dpath.sv
// ----------------------------------------------------------------------------
// xs256_dpath
// Datapath for the generator: state words, star-star scrambler and state
// update, and the splitmix64 seed mixer built around one 32x32 multiplier.
// ----------------------------------------------------------------------------
module xs256_dpath
    import xs256_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [WordWidth-1:0] seed,
    output logic [WordWidth-1:0] value,
    output logic [FracWidth-1:0] unit_fraction
);

    logic [WordWidth-1:0] gen_words_reg [NumWords];
    logic [WordWidth-1:0] counter_reg;
    logic [WordWidth-1:0] z_reg;
    logic [WordWidth-1:0] mul_reg;
    logic [WordWidth-1:0] value_reg;

    logic [WordWidth-1:0] counter_sum;
    logic [WordWidth-1:0] mul_const;
    logic [HalfWidth-1:0] mul_op_a;
    logic [HalfWidth-1:0] mul_op_b;
    logic [WordWidth-1:0] mul_prod;
    logic [WordWidth-1:0] mul_next;

    logic [WordWidth-1:0] times5;
    logic [WordWidth-1:0] rotated;
    logic [WordWidth-1:0] scrambled;
    logic [WordWidth-1:0] s2_x;
    logic [WordWidth-1:0] s3_x;
    logic [WordWidth-1:0] s1_n;
    logic [WordWidth-1:0] s0_n;
    logic [WordWidth-1:0] s2_n;
    logic [WordWidth-1:0] s3_n;

    // Star-star scrambler of word one: rotl(w1 * 5, 7) * 9 by shift and add.
    assign times5    = gen_words_reg[1] + {gen_words_reg[1][WordWidth-3:0], 2'b00};
    assign rotated   = {times5[WordWidth-8:0], times5[WordWidth-1:WordWidth-7]};
    assign scrambled = rotated + {rotated[WordWidth-4:0], 3'b000};

    // Xoshiro256 xor, shift and rotate update.
    assign s2_x = gen_words_reg[2] ^ gen_words_reg[0];
    assign s3_x = gen_words_reg[3] ^ gen_words_reg[1];
    assign s1_n = gen_words_reg[1] ^ s2_x;
    assign s0_n = gen_words_reg[0] ^ s3_x;
    assign s2_n = s2_x ^ {gen_words_reg[1][WordWidth-18:0], 17'd0};
    assign s3_n = {s3_x[18:0], s3_x[WordWidth-1:19]};

    // Splitmix64 counter step.
    assign counter_sum = counter_reg + GOLDEN_STEP;

    // Product mod 2^64 from three 32x32 partial products, one per cycle.
    assign mul_const = (cmd.mul_sel == MUL_SEL_B) ? MIX_MUL_B : MIX_MUL_A;
    assign mul_op_a  = (cmd.mul_phase == MUL_HI_LO) ? z_reg[WordWidth-1:HalfWidth]
                                                    : z_reg[HalfWidth-1:0];
    assign mul_op_b  = (cmd.mul_phase == MUL_LO_HI) ? mul_const[WordWidth-1:HalfWidth]
                                                    : mul_const[HalfWidth-1:0];
    assign mul_prod  = WordWidth'(mul_op_a) * WordWidth'(mul_op_b);
    assign mul_next  = (cmd.mul_phase == MUL_LO_LO)
                       ? mul_prod
                       : mul_reg + {mul_prod[HalfWidth-1:0], {HalfWidth{1'b0}}};

    // Generator state words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                gen_words_reg[i] <= '0;
            end
        end
        else if (cmd.draw)
        begin
            gen_words_reg[0] <= s0_n;
            gen_words_reg[1] <= s1_n;
            gen_words_reg[2] <= s2_n;
            gen_words_reg[3] <= s3_n;
        end
        else if (cmd.store)
        begin
            gen_words_reg[cmd.word_idx] <= mul_reg ^ (mul_reg >> 31);
        end
    end

    // Seed mixer registers and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            counter_reg <= seed;
        end
        else if (cmd.inc)
        begin
            counter_reg <= counter_sum;
        end

        if (cmd.inc)
        begin
            z_reg <= counter_sum ^ (counter_sum >> 30);
        end
        else if (cmd.mix27)
        begin
            z_reg <= mul_reg ^ (mul_reg >> 27);
        end

        if (cmd.mul_en)
        begin
            mul_reg <= mul_next;
        end

        if (cmd.draw)
        begin
            value_reg <= scrambled;
        end
    end

    assign value         = value_reg;
    assign unit_fraction = value_reg[WordWidth-1:FracShift];

endmodule

// File: bench/xs256_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xs256_draw_checker
// Watches both stream channels of the xoshiro256** core. It keeps its own copy
// of the four state words and works out the value and unit fraction of each
// accepted draw request. Each accepted result is compared with the oldest
// expected draw, and the number of mismatches is handed to the testbench top.
// ----------------------------------------------------------------------------
module xs256_draw_checker
    import xs256_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [WordWidth-1:0]    s_tdata,   // [63:0] seed
    input  logic                    s_tuser,   // [0] command
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OutDataWidth-1:0] m_tdata,   // [63:0] value, [115:64] unit_fraction
    output int                      fail_count,
    output int                      pending_draws
);

    typedef struct packed {
        logic [WordWidth-1:0] value;
        logic [FracWidth-1:0] unit_fraction;
    } draw_result_t;

    logic [WordWidth-1:0] state_words [NumWords];
    draw_result_t         expected_draws [$];
    int                   mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [WordWidth-1:0] rotl64(input logic [WordWidth-1:0] word,
                                                    input int unsigned amount);
        return (word << amount) | (word >> (WordWidth - amount));
    endfunction

    // Track the generator state and compare each result with the oldest draw.
    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t         oldest;
        draw_result_t         predicted;
        logic [WordWidth-1:0] counter;
        logic [WordWidth-1:0] mixed;
        logic [WordWidth-1:0] shifted;
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                state_words[i] = '0;
            end
            expected_draws.delete();
            pending_draws = 0;
        end
        else
        begin
            // A result accepted at this edge always belongs to an earlier draw.
            if (m_tvalid && m_tready)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("unexpected result: value %h, unit_fraction %h",
                           m_tdata[WordWidth-1:0], m_tdata[WordWidth +: FracWidth]);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_draws.pop_front();
                    if (m_tdata[WordWidth-1:0] !== oldest.value)
                    begin
                        $error("value: expected %h, actual %h",
                               oldest.value, m_tdata[WordWidth-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[WordWidth +: FracWidth] !== oldest.unit_fraction)
                    begin
                        $error("unit_fraction: expected %h, actual %h",
                               oldest.unit_fraction, m_tdata[WordWidth +: FracWidth]);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_DRAW)
                begin
                    // Star-star output of the current state, then one xoshiro step.
                    predicted.value = rotl64(state_words[1] * 64'd5, 7) * 64'd9;
                    predicted.unit_fraction = predicted.value[WordWidth-1:FracShift];
                    expected_draws.push_back(predicted);

                    shifted = state_words[1] << 17;
                    state_words[2] = state_words[2] ^ state_words[0];
                    state_words[3] = state_words[3] ^ state_words[1];
                    state_words[1] = state_words[1] ^ state_words[2];
                    state_words[0] = state_words[0] ^ state_words[3];
                    state_words[2] = state_words[2] ^ shifted;
                    state_words[3] = rotl64(state_words[3], 45);
                end
                else
                begin
                    // Seed load: four splitmix64 outputs replace the whole state.
                    counter = s_tdata;
                    for (int i = 0; i < NumWords; i++)
                    begin
                        counter = counter + GOLDEN_STEP;
                        mixed = (counter ^ (counter >> 30)) * MIX_MUL_A;
                        mixed = (mixed ^ (mixed >> 27)) * MIX_MUL_B;
                        state_words[i] = mixed ^ (mixed >> 31);
                    end
                end
            end
            pending_draws = expected_draws.size();
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the xoshiro256** generator core. A short directed
// sequence covers draws before any seed, extreme seeds and back-to-back seeds;
// then about two thousand random requests, mostly draws with some reseeds,
// are sent while both stream sides idle at random outside one steady stretch.
// ----------------------------------------------------------------------------
module testbench
    import xs256_pkg::*;
();

    localparam int QuietLimit  = 2000;
    localparam int RandomCount = 2000;
    localparam int DrainCycles = 60;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [WordWidth-1:0]    s_tdata;   // [63:0] seed
    logic                    s_tuser;   // [0] command
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutDataWidth-1:0] m_tdata;   // [63:0] value, [115:64] unit_fraction

    int   fail_count;
    int   pending_draws;
    int   quiet_cycles;
    logic steady_flow;

    xoshiro256_starstar_generator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    xs256_draw_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_draws (pending_draws)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: stall at random except during the steady stretch.
    always @(negedge clk)
    begin
        m_tready <= steady_flow || ($urandom_range(99) >= 9);
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entered at a falling edge; returns at the falling edge after acceptance.
    // Valid is left high so that the next request can follow without a gap.
    task automatic send_request(input logic command, input logic [WordWidth-1:0] seed_word);
        while (!steady_flow && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= seed_word;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic                 command;
        logic [WordWidth-1:0] seed_word;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = CMD_SEED;
        s_tdata     = '0;
        steady_flow = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Draws before any seed return zero; the seed field is ignored.
        send_request(CMD_DRAW, '0);
        send_request(CMD_DRAW, '1);
        // Extreme and patterned seeds.
        send_request(CMD_SEED, '0);
        send_request(CMD_DRAW, '0);
        send_request(CMD_DRAW, '1);
        send_request(CMD_SEED, '1);
        send_request(CMD_DRAW, 64'h5555_5555_5555_5555);
        send_request(CMD_SEED, 64'h8000_0000_0000_0000);
        send_request(CMD_DRAW, '0);
        send_request(CMD_SEED, 64'h0000_0000_0000_0001);
        send_request(CMD_DRAW, '0);
        send_request(CMD_SEED, 64'h5555_5555_5555_5555);
        send_request(CMD_DRAW, '0);
        send_request(CMD_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(CMD_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
        // A seed right after a seed discards the first one.
        send_request(CMD_SEED, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_SEED, 64'hFEDC_BA98_7654_3210);
        send_request(CMD_DRAW, {$urandom, $urandom});
        send_request(CMD_DRAW, {$urandom, $urandom});
        send_request(CMD_DRAW, {$urandom, $urandom});

        // Random requests: mostly draws, reseeds now and then.
        for (int i = 0; i < RandomCount; i++)
        begin
            steady_flow = (i >= 700) && (i < 1100);
            command = ($urandom_range(99) < 8) ? CMD_SEED : CMD_DRAW;
            seed_word = {$urandom, $urandom};
            if ($urandom_range(9) == 0)
            begin
                seed_word = $urandom_range(1) ? '1 : '0;
            end
            send_request(command, seed_word);
        end
        steady_flow = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_draws != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
